@@ src/mwh_pkg.sv @@
// Package for the word hash core: constants, shared types and the byte mask function.
// It depends on nothing; every other file in src uses it by scoped names.

package mwh_pkg;

	localparam logic [31:0] HASH_MULT = 32'h7fd6_52ad;
	localparam logic [31:0] HASH_SEED = 32'hdead_beef;

	localparam int WORD_W  = 32;
	localparam int COUNT_W = 3;
	localparam int IN_TDATA_W = 40;

	localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

	typedef enum logic [1:0] {
		PRE_ADD,
		PRE_XS16,
		PRE_XS10,
		PRE_XS17
	} pre_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_XS,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3
	} state_t;

	typedef struct packed {
		pre_op_t pre_op;
		logic    mul_en;
	} unit_ctrl_t;

	typedef struct packed {
		unit_ctrl_t unit;
		logic       acc_ld;
		logic       seed_ld;
		logic       out_ld;
	} seq_ctrl_t;

	function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] count);
		logic [WORD_W-1:0] mask;
		case (count)
			3'd0:    mask = 32'h0000_0000;
			3'd1:    mask = 32'h0000_00ff;
			3'd2:    mask = 32'h0000_ffff;
			3'd3:    mask = 32'h00ff_ffff;
			default: mask = 32'hffff_ffff;
		endcase
		return mask;
	endfunction

endpackage

@@ src/mwh_mix_unit.sv @@
// Shared arithmetic unit: an add or xor-shift on the running hash, then an optional
// multiply by the hash constant. Depends on mwh_pkg.

module mwh_mix_unit (
	input  logic [31:0]              acc,
	input  logic [31:0]              word,
	input  mwh_pkg::unit_ctrl_t      ctrl,
	output logic [31:0]              result
);

	logic [31:0] pre;

	always_comb begin
		case (ctrl.pre_op)
			mwh_pkg::PRE_ADD:  pre = acc + word;
			mwh_pkg::PRE_XS16: pre = acc ^ (acc >> 16);
			mwh_pkg::PRE_XS10: pre = acc ^ (acc >> 10);
			mwh_pkg::PRE_XS17: pre = acc ^ (acc >> 17);
			default:           pre = acc;
		endcase
	end

	assign result = ctrl.mul_en ? (pre * mwh_pkg::HASH_MULT) : pre;

endmodule

@@ src/mwh_seq.sv @@
// Sequencer of the word hash core: steps the shared unit through the mix and
// finalization of one item. Depends on mwh_pkg.

module mwh_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic                 has_mix,
	input  logic                 fin,
	input  logic                 out_free,
	output logic                 in_ready,
	output mwh_pkg::seq_ctrl_t   ctrl
);

	mwh_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mwh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		ctrl.unit.pre_op = mwh_pkg::PRE_ADD;
		ctrl.unit.mul_en = 1'b0;
		ctrl.acc_ld      = 1'b0;
		ctrl.seed_ld     = 1'b0;
		ctrl.out_ld      = 1'b0;
		case (state_q)
			mwh_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					state_d = mwh_pkg::ST_ADD;
				end
			end
			mwh_pkg::ST_ADD: begin
				ctrl.unit.pre_op = mwh_pkg::PRE_ADD;
				ctrl.unit.mul_en = 1'b1;
				ctrl.acc_ld      = 1'b1;
				if (!has_mix) begin
					state_d = mwh_pkg::ST_FIN2;
				end else if (fin) begin
					state_d = mwh_pkg::ST_FIN1;
				end else begin
					state_d = mwh_pkg::ST_XS;
				end
			end
			mwh_pkg::ST_XS: begin
				ctrl.unit.pre_op = mwh_pkg::PRE_XS16;
				ctrl.acc_ld      = 1'b1;
				state_d          = mwh_pkg::ST_IDLE;
			end
			mwh_pkg::ST_FIN1: begin
				ctrl.unit.pre_op = mwh_pkg::PRE_XS16;
				ctrl.unit.mul_en = 1'b1;
				ctrl.acc_ld      = 1'b1;
				state_d          = mwh_pkg::ST_FIN2;
			end
			mwh_pkg::ST_FIN2: begin
				ctrl.unit.pre_op = mwh_pkg::PRE_XS10;
				ctrl.unit.mul_en = 1'b1;
				ctrl.acc_ld      = 1'b1;
				state_d          = mwh_pkg::ST_FIN3;
			end
			mwh_pkg::ST_FIN3: begin
				ctrl.unit.pre_op = mwh_pkg::PRE_XS17;
				if (out_free) begin
					ctrl.out_ld  = 1'b1;
					ctrl.seed_ld = 1'b1;
					state_d      = mwh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mwh_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/murmur_style_word_hash_core.sv @@
// Top level of the word hash core: input capture, running hash, output register.
// Depends on mwh_pkg, mwh_mix_unit and mwh_seq.
//
// Channel  Direction  Handshake              Contents
// s_axis   in         s_axis_tvalid/tready   word_data, byte_count in tdata; last_word in tlast
// m_axis   out        m_axis_tvalid/tready   hash_value in tdata
//
// After acceptance a full word that does not end the message steps through ST_ADD and ST_XS,
// then the core is back in ST_IDLE to take the next item. A finalizing item steps through
// ST_ADD, ST_FIN1, ST_FIN2 and ST_FIN3 (no ST_FIN1 when its count is zero), and ST_FIN3 waits
// for the output register to free; its result is registered as ST_FIN3 ends, and the core then
// returns to ST_IDLE. The steps share one multiplier, used at most once per cycle.
// Reset loads the seed into the running hash and empties the output register.
// Input is not taken while an item is in progress; a held result stalls only finalization.

module murmur_style_word_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [31:0] word_data, [34:32] byte_count, [39:35] zero
	input  logic        s_axis_tlast,  // last_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [31:0] hash_value
);

	logic        in_fire;
	logic [31:0] word_data;
	logic [2:0]  byte_count;
	logic [31:0] acc_q;
	logic [31:0] word_q;
	logic        has_mix_q;
	logic        fin_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic [31:0] unit_result;
	logic        out_free;

	mwh_pkg::seq_ctrl_t ctrl;

	assign word_data  = s_axis_tdata[31:0];
	assign byte_count = s_axis_tdata[34:32];
	assign in_fire    = s_axis_tvalid && s_axis_tready;
	assign out_free   = !out_valid_q || m_axis_tready;

	mwh_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.has_mix  (has_mix_q),
		.fin      (fin_q),
		.out_free (out_free),
		.in_ready (s_axis_tready),
		.ctrl     (ctrl)
	);

	mwh_mix_unit u_unit (
		.acc    (acc_q),
		.word   (word_q),
		.ctrl   (ctrl.unit),
		.result (unit_result)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_q <= word_data & mwh_pkg::byte_mask(byte_count);
		end
		if (ctrl.out_ld) begin
			out_data_q <= unit_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= mwh_pkg::HASH_SEED;
			has_mix_q   <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				has_mix_q <= (byte_count != 3'd0);
				fin_q     <= s_axis_tlast || (byte_count < mwh_pkg::FULL_COUNT);
			end
			if (ctrl.seed_ld) begin
				acc_q <= mwh_pkg::HASH_SEED;
			end else if (ctrl.acc_ld) begin
				acc_q <= unit_result;
			end
			if (ctrl.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_axis_tready)
		else $error("input taken again while an item is in progress");

	a_no_output_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_ld |-> (!out_valid_q || m_axis_tready))
		else $error("result loaded over one not yet taken");

	a_seed_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_ld |=> (acc_q == mwh_pkg::HASH_SEED && out_valid_q))
		else $error("seed not reloaded after a result");

	a_fin_on_short_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (byte_count < mwh_pkg::FULL_COUNT)) |=> fin_q)
		else $error("short item not marked for finalization");

endmodule
